@@ rtl/kth_permutation_unrank_top_macros.svh @@
// Assertion macros shared by the permutation unranking RTL.
`ifndef KTH_PERMUTATION_UNRANK_TOP_MACROS_SVH
`define KTH_PERMUTATION_UNRANK_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KPERM_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kperm: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define KPERM_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kperm: next-cycle check failed");

`endif

@@ rtl/kperm_pkg.sv @@
// Types, constants, factorial table and microcode ROM for the permutation unranker.
package kperm_pkg;

   localparam int RANK_W  = 31;   // width of the rank field
   localparam int DIGIT_W = 4;    // width of a digit and of the size field
   localparam int FACT_W  = 29;   // holds factorials up to 12!
   localparam int CNT_W   = 5;    // counts up to RANK_W division steps
   localparam int STEP_W  = 4;

   typedef logic [STEP_W-1:0]  step_type;
   typedef logic [FACT_W-1:0]  fact_type;
   typedef logic [DIGIT_W-1:0] digit_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_MOD_INIT,
      OP_DIV_STEP,
      OP_DEC,
      OP_DIG_INIT,
      OP_PICK
   } op_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_REQ,
      C_CNT_MORE,
      C_OUT_BUSY,
      C_MORE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   localparam step_type STEP_ACCEPT   = 4'd0;
   localparam step_type STEP_MOD_INIT = 4'd1;
   localparam step_type STEP_MOD_DIV  = 4'd2;
   localparam step_type STEP_DEC      = 4'd3;
   localparam step_type STEP_DIG_INIT = 4'd4;
   localparam step_type STEP_DIG_DIV  = 4'd5;
   localparam step_type STEP_PICK     = 4'd6;
   localparam step_type STEP_LOOP     = 4'd7;
   localparam step_type STEP_DONE     = 4'd8;

   function automatic fact_type fact(input digit_type m);
      fact_type f;
      case (m)
         4'd0:    f = 29'd1;
         4'd1:    f = 29'd1;
         4'd2:    f = 29'd2;
         4'd3:    f = 29'd6;
         4'd4:    f = 29'd24;
         4'd5:    f = 29'd120;
         4'd6:    f = 29'd720;
         4'd7:    f = 29'd5040;
         4'd8:    f = 29'd40320;
         4'd9:    f = 29'd362880;
         4'd10:   f = 29'd3628800;
         4'd11:   f = 29'd39916800;
         4'd12:   f = 29'd479001600;
         default: f = 29'd1;
      endcase
      return f;
   endfunction

   function automatic uword_type ucode(input step_type pc);
      uword_type uw;
      case (pc)
         STEP_ACCEPT:   uw = '{OP_ACCEPT,   C_NO_REQ,   STEP_ACCEPT};
         STEP_MOD_INIT: uw = '{OP_MOD_INIT, C_NEXT,     STEP_ACCEPT};
         STEP_MOD_DIV:  uw = '{OP_DIV_STEP, C_CNT_MORE, STEP_MOD_DIV};
         STEP_DEC:      uw = '{OP_DEC,      C_NEXT,     STEP_ACCEPT};
         STEP_DIG_INIT: uw = '{OP_DIG_INIT, C_NEXT,     STEP_ACCEPT};
         STEP_DIG_DIV:  uw = '{OP_DIV_STEP, C_CNT_MORE, STEP_DIG_DIV};
         STEP_PICK:     uw = '{OP_PICK,     C_OUT_BUSY, STEP_PICK};
         STEP_LOOP:     uw = '{OP_NOP,      C_MORE,     STEP_DIG_INIT};
         STEP_DONE:     uw = '{OP_NOP,      C_ALWAYS,   STEP_ACCEPT};
         default:       uw = '{OP_NOP,      C_ALWAYS,   STEP_ACCEPT};
      endcase
      return uw;
   endfunction

endpackage

@@ rtl/kth_permutation_unrank_top.sv @@
// Permutation unranker: a beat carries a size n and a one-based rank k, and the
// block returns the k-th lexicographic permutation of 1..n as n beats, one digit
// each, with tlast on the final digit; k is taken modulo n!, and zero gives n..1.
// One item is worked on at a time, driven by a nine-step microcode ROM over a
// single restoring divider that retires one quotient bit per cycle. The rank
// reduction is bit-serial over all RANK_W rank bits, and each digit divides out
// IW = clog2(MAX_N) quotient bits. The next item is accepted while the final
// digit still waits in the output register.
`include "kth_permutation_unrank_top_macros.svh"

module kth_permutation_unrank_top #(
   parameter int MAX_N = 9
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [39:0] req_tdata,   // [3:0] size_n, [34:4] rank_k, [39:35] zero
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [3:0] digit, [7:4] zero
   output logic       rsp_tlast
);
   import kperm_pkg::*;

   localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

   step_type                pc_ff, pc_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   digit_type               n_ff, n_in;
   digit_type               m_ff, m_in;
   fact_type                r_ff, r_in;
   fact_type                rem_ff, rem_in;
   fact_type                div_ff, div_in;
   logic [RANK_W-1:0]       sh_ff, sh_in;
   digit_type               list_ff [MAX_N];
   digit_type               list_in [MAX_N];
   digit_type               rsp_digit_ff, rsp_digit_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   uword_type               uw;
   logic                    req_fire;
   logic                    out_busy;
   logic                    pick_en;
   logic                    jump;
   digit_type               size_n;
   digit_type               n_clamp;
   logic [RANK_W-1:0]       rank_k;
   logic [FACT_W:0]         trial;
   logic                    ge;
   logic [IW-1:0]           idx;
   fact_type                fact_val;

   assign uw       = ucode(pc_ff);
   assign size_n   = req_tdata[3:0];
   assign rank_k   = req_tdata[34:4];
   assign req_tready = (uw.op == OP_ACCEPT);
   assign req_fire = req_tvalid && req_tready;
   assign out_busy = rsp_valid_ff && !rsp_tready;
   assign pick_en  = (uw.op == OP_PICK) && !out_busy;
   assign idx      = sh_ff[IW-1:0];

   assign n_clamp = (size_n == '0) ? digit_type'(1) :
                    (size_n > digit_type'(MAX_N)) ? digit_type'(MAX_N) : size_n;

   // One factorial lookup serves both the rank reduction and the digit division.
   assign fact_val = fact((uw.op == OP_MOD_INIT) ? n_ff : m_ff);

   // Restoring division step: dividend bits shift out of the top of sh_ff while
   // quotient bits shift in at the bottom.
   assign trial = {rem_ff, sh_ff[RANK_W-1]};
   assign ge    = (trial >= {1'b0, div_ff});

   always_comb begin
      case (uw.cond)
         C_NEXT:     jump = 1'b0;
         C_ALWAYS:   jump = 1'b1;
         C_NO_REQ:   jump = !req_tvalid;
         C_CNT_MORE: jump = (cnt_ff != CNT_W'(1));
         C_OUT_BUSY: jump = out_busy;
         C_MORE:     jump = !rsp_last_ff;
         default:    jump = 1'b0;
      endcase
   end

   always_comb begin
      pc_in        = jump ? uw.target : pc_ff + step_type'(1);
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      r_in         = r_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      sh_in        = sh_ff;
      list_in      = list_ff;
      rsp_digit_in = rsp_digit_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (uw.op)
         OP_ACCEPT: begin
            if (req_fire) begin
               n_in  = n_clamp;
               sh_in = rank_k;
               for (int j = 0; j < MAX_N; j++) begin
                  list_in[j] = digit_type'(j + 1);
               end
            end
         end
         OP_MOD_INIT: begin
            div_in = fact_val;
            rem_in = '0;
            cnt_in = CNT_W'(RANK_W);
            m_in   = n_ff - digit_type'(1);
         end
         OP_DIV_STEP: begin
            rem_in = ge ? FACT_W'(trial - {1'b0, div_ff}) : trial[FACT_W-1:0];
            sh_in  = {sh_ff[RANK_W-2:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         OP_DEC: begin
            // Zero-based rank: a remainder of zero wraps to the last permutation.
            r_in = (rem_ff == '0) ? div_ff - fact_type'(1) : rem_ff - fact_type'(1);
         end
         OP_DIG_INIT: begin
            // The quotient is below MAX_N, so only the low IW rank bits need stepping.
            div_in = fact_val;
            rem_in = FACT_W'(r_ff >> IW);
            sh_in  = {r_ff[IW-1:0], (RANK_W-IW)'(0)};
            cnt_in = CNT_W'(IW);
         end
         OP_PICK: begin
            if (pick_en) begin
               rsp_digit_in = list_ff[idx];
               rsp_last_in  = (m_ff == '0);
               rsp_valid_in = 1'b1;
               r_in         = rem_ff;
               m_in         = m_ff - digit_type'(1);
               for (int j = 0; j < MAX_N - 1; j++) begin
                  if (IW'(j) >= idx) begin
                     list_in[j] = list_ff[j + 1];
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_ACCEPT;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b1;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      cnt_ff       <= cnt_in;
      n_ff         <= n_in;
      m_ff         <= m_in;
      r_ff         <= r_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      sh_ff        <= sh_in;
      list_ff      <= list_in;
      rsp_digit_ff <= rsp_digit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_digit_ff};
   assign rsp_tlast  = rsp_last_ff;

   `KPERM_ASSERT_IMP(a_ready_only_at_accept, clock, reset, req_tready, pc_ff == STEP_ACCEPT)
   `KPERM_ASSERT_IMP(a_div_count_live, clock, reset, uw.op == OP_DIV_STEP, cnt_ff != '0)
   `KPERM_ASSERT_IMP(a_index_in_range, clock, reset, pick_en, 4'(idx) <= m_ff)
   `KPERM_ASSERT_NXT(a_last_on_final, clock, reset, pick_en && m_ff == '0, rsp_tlast && rsp_tvalid)

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the permutation unranker, checked beat by beat.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import kperm_pkg::*;

   localparam int LARGEST_N = 9;

   typedef struct packed {
      digit_type digit;
      logic      last;
   } perm_beat_type;

   logic clock;
   logic reset = 1'b1;

   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [39:0]         req_tdata = '0;   // [3:0] size_n, [34:4] rank_k, [39:35] zero
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;        // [3:0] digit, [7:4] zero
   logic                rsp_tlast;

   perm_beat_type digits_due[$];
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_stall_pct = 0;
   int unsigned   items_sent = 0;
   int unsigned   beats_checked = 0;
   int unsigned   error_count = 0;

   kth_permutation_unrank_top #(
      .MAX_N(LARGEST_N)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("tb: failure");
      $finish;
   end

   function automatic longint unsigned factorial(int unsigned m);
      longint unsigned f;
      f = 1;
      for (int unsigned i = 2; i <= m; i++) f *= i;
      return f;
   endfunction

   // Size zero behaves as one, and sizes past the largest supported one saturate.
   function automatic int unsigned effective_size(digit_type size_field);
      if (size_field == 0) return 1;
      if (size_field > LARGEST_N) return LARGEST_N;
      return size_field;
   endfunction

   // Factorial-number-system unranking of the one-based rank into digits_due.
   function automatic void unrank_into_digits_due(digit_type size_field,
                                                  logic [RANK_W-1:0] rank);
      int unsigned     n;
      longint unsigned total, r, f, idx, seen;
      bit [LARGEST_N:1] taken;
      int unsigned     pick;
      perm_beat_type   beat;
      n = effective_size(size_field);
      total = factorial(n);
      r = (rank % total + total - 1) % total;
      taken = '0;
      for (int unsigned pos = 0; pos < n; pos++) begin
         f = factorial(n - 1 - pos);
         idx = r / f;
         r = r % f;
         seen = 0;
         pick = 0;
         for (int unsigned d = 1; d <= n; d++) begin
            if (!taken[d]) begin
               if (seen == idx) begin
                  pick = d;
                  break;
               end
               seen++;
            end
         end
         taken[pick] = 1'b1;
         beat.digit = digit_type'(pick);
         beat.last = (pos + 1 == n);
         digits_due.push_back(beat);
      end
   endfunction

   function automatic logic [RANK_W-1:0] random_rank(int unsigned n);
      longint unsigned span, value;
      span = factorial(n);
      case ($urandom_range(3))
         0: value = $urandom();
         1: value = $urandom_range(0, 2 * span);
         // Just around a multiple of n!, where the rank wraps.
         2: value = longint'($urandom_range(1, (2**31 - 1) / span)) * span - 1
                    + $urandom_range(2);
         default: value = $urandom_range(1) ? 0 : 31'h7fff_ffff;
      endcase
      return value[RANK_W-1:0];
   endfunction

   // Valid stays high after the accepting edge; the next call either replaces the
   // data or lowers valid, so each step gets at most one assignment to it.
   task automatic send_item(input digit_type size_field, input logic [RANK_W-1:0] rank);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tdata <= {5'b0, rank, size_field};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      unrank_into_digits_due(size_field, rank);
      items_sent++;
   endtask

   task automatic wait_all_digits();
      req_tvalid <= 1'b0;
      while (digits_due.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      perm_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digits_due.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual tdata %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = digits_due.pop_front();
            beats_checked++;
            if (rsp_tdata !== {4'b0, want.digit} || rsp_tlast !== want.last) begin
               $display("%0t: mismatch, expected tdata %h last %b, actual tdata %h last %b",
                        $time, {4'b0, want.digit}, want.last, rsp_tdata, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Size zero, sizes past the largest, and size one with extreme ranks.
   task automatic test_size_saturation();
      send_item(4'd0, 31'd5);
      send_item(4'd15, 31'h7fff_ffff);
      send_item(4'd10, 31'd1);
      send_item(4'd12, 31'd7);
      send_item(4'd1, 31'd0);
      send_item(4'd1, 31'h7fff_ffff);
      send_item(4'd1, 31'd1);
   endtask

   // Ranks of zero, one and multiples of n!, where the order wraps around.
   task automatic test_rank_wrap();
      send_item(4'd9, 31'd0);
      send_item(4'd9, 31'd1);
      send_item(4'd9, 31'd362879);
      send_item(4'd9, 31'd362880);
      send_item(4'd9, 31'd362881);
      send_item(4'd9, 31'h7fff_ffff);
      send_item(4'd2, 31'd1);
      send_item(4'd2, 31'd2);
      send_item(4'd2, 31'd3);
      send_item(4'd3, 31'd4);
      send_item(4'd8, 31'd120960);
      send_item(4'd5, 31'h5555_5555);
      send_item(4'd6, 31'h2aaa_aaaa);
   endtask

   // Mostly legal sizes with ranks spread over the whole field, some out of range.
   task automatic test_random_perms(input int unsigned count);
      int unsigned sel;
      digit_type   size_field;
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) begin
            sel = $urandom_range(10, 16);
            size_field = (sel == 16) ? 4'd0 : digit_type'(sel);
         end else begin
            size_field = digit_type'($urandom_range(1, LARGEST_N));
         end
         send_item(size_field, random_rank(effective_size(size_field)));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 28;
      recv_stall_pct = 81;
      test_size_saturation();
      test_rank_wrap();
      test_random_perms(70);
      // Let the block run completely dry before the next phase.
      wait_all_digits();

      send_idle_pct = 81;
      recv_stall_pct = 28;
      test_random_perms(70);
      wait_all_digits();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_perms(70);
      wait_all_digits();
      repeat (150) @(posedge clock);

      if (digits_due.size() != 0) begin
         $display("%0t: %0d expected digits never arrived", $time, digits_due.size());
         error_count++;
      end
      $display("tb: %0d ranks unranked, %0d digit beats compared, %0d errors",
               items_sent, beats_checked, error_count);
      $display("tb: sizes 0 to 15, ranks at zero, wrap points and full range, three stall mixes");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
